@@ sv/tga_rle_pixel_decoder_macros.svh @@
// Assertion helpers used by the checker file of the run-length decoder.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("run-length decoder check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define TRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("run-length decoder check failed (next cycle)");

`endif

@@ sv/trle_pkg.sv @@
package trle_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned PIX_W           = 32;
    localparam int unsigned PIX_BYTES       = PIX_W / BYTE_W;
    localparam int unsigned REP_W           = 8;
    localparam int unsigned DIM_W           = 16;
    localparam int unsigned BPP_W           = 3;
    localparam int unsigned TOTAL_W         = 2 * DIM_W;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = DIM_W;
    localparam int unsigned TDATA_W         = PIX_W + REP_W;
    localparam int unsigned DEFAULT_MAX_BPP = 4;

    // Header byte layout.
    localparam logic [BYTE_W-1:0] HDR_COUNT_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] HDR_RUN_FLAG   = 8'h80;

    // Reset values of the configuration registers.
    localparam logic [BPP_W-1:0]   BPP_RESET    = 3'd4;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 16'd1;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 16'd1;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET  = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPP    = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_idx_t;

endpackage

@@ sv/tga_rle_pixel_decoder.sv @@
// A result is registered: it appears on the master side in the cycle after the byte that
// completes it (or the header that overruns the image) is accepted.
// Throughput: one compressed byte per cycle; the output register stalls input only while a
// result is held and the master side is not ready.
// Reset: rst_n is asynchronous and active low; it restores the default configuration
// (4 bytes per pixel, 1 x 1 image) and puts the decoder in front of a packet header.
module tga_rle_pixel_decoder #(
    parameter int unsigned MAX_BYTES_PER_PIXEL = trle_pkg::DEFAULT_MAX_BPP
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration write port: 0 bytes per pixel, 1 image width, 2 image height.
    input  logic                            cfg_we,
    input  logic [trle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trle_pkg::CFG_DATA_W-1:0] cfg_data,

    // Compressed byte stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [trle_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte

    // Decoded pixel stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [trle_pkg::TDATA_W-1:0]    m_axis_tdata,   // [31:0] pixel_value,
                                                            // [39:32] repeat_count
    output logic                            m_axis_tlast,   // image_done
    output logic                            m_axis_tuser    // error_code
);
    import trle_pkg::*;

    // The byte position counter must index every byte of the widest pixel, and the
    // incremented position must hold the pixel size itself for the completion compare.
    localparam int unsigned POS_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
    localparam int unsigned EFF_W = $clog2(MAX_BYTES_PER_PIXEL + 1);

    // Configuration registers. The pixel total is kept as a register and recomputed
    // on every width or height write, so the per-byte path only sees an add and compare.
    logic [BPP_W-1:0]   bpp_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [DIM_W-1:0]   mul_a;
    logic [DIM_W-1:0]   mul_b;

    // Decoder state.
    logic               expect_header_reg, expect_header_next;
    logic               run_packet_reg, run_packet_next;
    logic [REP_W-1:0]   pixels_left_reg, pixels_left_next;
    logic [POS_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [PIX_W-1:0]   pixel_asm_reg, pixel_asm_next;
    logic [TOTAL_W-1:0] pixels_done_reg, pixels_done_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   out_pixel_reg;
    logic [REP_W-1:0]   out_rep_reg;
    logic               out_done_reg;
    logic               out_err_reg;

    // Result of the current transaction, if any.
    logic               res_valid;
    logic [PIX_W-1:0]   res_pixel;
    logic [REP_W-1:0]   res_rep;
    logic               res_done;
    logic               res_err;

    logic               in_acc;
    logic [EFF_W-1:0]   eff_bpp;
    logic [EFF_W-1:0]   pos_inc;
    logic [PIX_W-1:0]   asm_wr;
    logic [REP_W-1:0]   hdr_len;
    logic [TOTAL_W:0]   hdr_sum;
    logic [REP_W-1:0]   rep;
    logic [REP_W-1:0]   left_after;
    logic [TOTAL_W-1:0] done_sum;
    logic               img_done;

    // A new byte is taken whenever the output register is empty or being drained.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Configuration: the multiplier pairs the incoming dimension with the
    // stored other one.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = width_reg;
        mul_b = height_reg;
        if (cfg_we && (cfg_index == CFG_WIDTH))
        begin
            mul_a = cfg_data;
        end
        if (cfg_we && (cfg_index == CFG_HEIGHT))
        begin
            mul_b = cfg_data;
        end
        total_next = TOTAL_W'(mul_a) * TOTAL_W'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    <= BPP_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            total_reg  <= TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BPP:
                begin
                    bpp_reg <= cfg_data[BPP_W-1:0];
                end
                CFG_WIDTH:
                begin
                    width_reg <= cfg_data;
                    total_reg <= total_next;
                end
                CFG_HEIGHT:
                begin
                    height_reg <= cfg_data;
                    total_reg  <= total_next;
                end
                default:
                begin
                    // Unused register index: the write has no effect.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-byte decode.
    // ------------------------------------------------------------------

    // A pixel size of zero behaves as one byte; anything above the maximum is clamped.
    always_comb
    begin
        if (bpp_reg == '0)
        begin
            eff_bpp = EFF_W'(1);
        end
        else if (32'(bpp_reg) > MAX_BYTES_PER_PIXEL)
        begin
            eff_bpp = EFF_W'(MAX_BYTES_PER_PIXEL);
        end
        else
        begin
            eff_bpp = EFF_W'(bpp_reg);
        end
    end

    // Drop the incoming byte into its lane; bytes beyond the 32-bit pixel are lost.
    always_comb
    begin
        asm_wr = pixel_asm_reg;
        for (int i = 0; i < PIX_BYTES; i++)
        begin
            if (32'(byte_pos_reg) == i)
            begin
                asm_wr[i*BYTE_W +: BYTE_W] = s_axis_tdata;
            end
        end
    end

    assign pos_inc = EFF_W'(byte_pos_reg) + EFF_W'(1);
    assign hdr_len = (s_axis_tdata & HDR_COUNT_MASK) + REP_W'(1);
    assign hdr_sum = {1'b0, pixels_done_reg} + (TOTAL_W + 1)'(hdr_len);

    assign rep        = run_packet_reg ? pixels_left_reg : REP_W'(1);
    assign left_after = run_packet_reg ? '0 : (pixels_left_reg - REP_W'(1));
    assign done_sum   = pixels_done_reg + TOTAL_W'(rep);
    assign img_done   = (done_sum == total_reg);

    always_comb
    begin
        expect_header_next = expect_header_reg;
        run_packet_next    = run_packet_reg;
        pixels_left_next   = pixels_left_reg;
        byte_pos_next      = byte_pos_reg;
        pixel_asm_next     = pixel_asm_reg;
        pixels_done_next   = pixels_done_reg;
        res_valid          = 1'b0;
        res_pixel          = asm_wr;
        res_rep            = rep;
        res_done           = img_done;
        res_err            = 1'b0;

        if (in_acc)
        begin
            if (expect_header_reg)
            begin
                if (hdr_sum > {1'b0, total_reg})
                begin
                    // The packet would run past the end of the image: report it,
                    // drop the image and look for the header of a new one.
                    pixels_done_next = '0;
                    run_packet_next  = 1'b0;
                    pixels_left_next = '0;
                    byte_pos_next    = '0;
                    pixel_asm_next   = '0;
                    res_valid        = 1'b1;
                    res_pixel        = '0;
                    res_rep          = '0;
                    res_done         = 1'b1;
                    res_err          = 1'b1;
                end
                else
                begin
                    expect_header_next = 1'b0;
                    run_packet_next    = |(s_axis_tdata & HDR_RUN_FLAG);
                    pixels_left_next   = hdr_len;
                    byte_pos_next      = '0;
                    pixel_asm_next     = '0;
                end
            end
            else if (pos_inc < eff_bpp)
            begin
                // Pixel not yet complete.
                byte_pos_next  = pos_inc[POS_W-1:0];
                pixel_asm_next = asm_wr;
            end
            else
            begin
                // Last byte of a pixel: emit it. A run packet ends after its one
                // pixel; a raw packet ends when its count runs out.
                byte_pos_next  = '0;
                pixel_asm_next = '0;
                res_valid      = 1'b1;
                if (img_done)
                begin
                    pixels_done_next   = '0;
                    pixels_left_next   = '0;
                    expect_header_next = 1'b1;
                end
                else
                begin
                    pixels_done_next   = done_sum;
                    pixels_left_next   = left_after;
                    expect_header_next = (left_after == '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            run_packet_reg    <= 1'b0;
            pixels_left_reg   <= '0;
            byte_pos_reg      <= '0;
            pixel_asm_reg     <= '0;
            pixels_done_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            expect_header_reg <= expect_header_next;
            run_packet_reg    <= run_packet_next;
            pixels_left_reg   <= pixels_left_next;
            byte_pos_reg      <= byte_pos_next;
            pixel_asm_reg     <= pixel_asm_next;
            pixels_done_reg   <= pixels_done_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: loads a new result whenever one is produced, which can
    // only happen when it is empty or being taken in the same cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_acc && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && res_valid)
        begin
            out_pixel_reg <= res_pixel;
            out_rep_reg   <= res_rep;
            out_done_reg  <= res_done;
            out_err_reg   <= res_err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_rep_reg, out_pixel_reg};
    assign m_axis_tlast  = out_done_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

@@ sv/trle_checker.sv @@
`include "tga_rle_pixel_decoder_macros.svh"

module trle_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [trle_pkg::TDATA_W-1:0]    m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tuser
);
    import trle_pkg::*;

    logic [REP_W-1:0]   rep_field;
    logic [PIX_W-1:0]   pix_field;
    logic [TDATA_W+1:0] out_bus;
    logic               err_shape_ok;
    logic               rep_ok;
    logic               stalled;

    assign rep_field    = m_axis_tdata[TDATA_W-1:PIX_W];
    assign pix_field    = m_axis_tdata[PIX_W-1:0];
    assign out_bus      = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
    assign err_shape_ok = m_axis_tlast && (rep_field == '0) && (pix_field == '0);
    assign rep_ok       = (rep_field != '0) && (rep_field <= REP_W'(128));
    assign stalled      = m_axis_tvalid && !m_axis_tready;

    // An error result always ends the image and carries no pixel.
    `TRLE_ASSERT_IMPLY(a_err_shape, clk, rst_n, m_axis_tvalid && m_axis_tuser, err_shape_ok)

    // A pixel result repeats between 1 and 128 times.
    `TRLE_ASSERT_IMPLY(a_rep_range, clk, rst_n, m_axis_tvalid && !m_axis_tuser, rep_ok)

    // With nothing held at the output, the decoder always takes the next byte.
    `TRLE_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready)

    // A stalled result stays put until it is taken.
    `TRLE_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, m_axis_tvalid && $stable(out_bus))

endmodule

bind tga_rle_pixel_decoder trle_checker u_trle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the TGA run-length pixel decoder.
//
// An initial block builds the compressed byte stream phase by phase: a short directed
// opening, then random phases that each program the pixel size and mostly the image geometry and then
// queue mostly well-formed packets with random content, plus some noise and some headers that
// overrun the image. A clocked driver feeds the queued bytes into the slave side, and a
// clocked monitor takes results from the master side. Every accepted byte goes through a
// bit-exact predictor of the decoder, and each accepted result is compared field by field
// with the oldest predicted one.
module tb;
    import trle_pkg::*;

    localparam int unsigned MAX_BPP      = DEFAULT_MAX_BPP;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned ITEM_GOAL    = 1450;
    localparam int unsigned CALM_AFTER   = 1250;
    localparam int unsigned REPORT_MAX   = 10;

    // Register index that the decoder does not implement; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // One decoded pixel run as it should leave the master side.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [REP_W-1:0] rep;
        logic             done;
        logic             err;
    } pixel_result_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    tga_rle_pixel_decoder #(
        .MAX_BYTES_PER_PIXEL(MAX_BPP)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] data_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [31:0] pixel_value, [39:32] repeat_count
        .m_axis_tlast  (m_axis_tlast),    // image_done
        .m_axis_tuser  (m_axis_tuser)     // error_code
    );

    // Bytes waiting to be offered on the slave side, and results still owed by the decoder.
    logic [BYTE_W-1:0] stream_bytes[$];
    pixel_result_t     pixels_due[$];

    int unsigned items_queued = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;

    // Random idling is switched per phase; calm turns it off for the closing stretch.
    bit idle_on = 1'b0;
    bit calm    = 1'b0;

    // Predictor copy of the configuration registers.
    logic [BPP_W-1:0] bpp_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // Predictor copy of the decoder state.
    logic        want_header;
    logic        in_run;
    logic [7:0]  left_in_packet;
    int unsigned byte_idx;
    logic [31:0] pix_acc;
    logic [31:0] image_pixels;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void reset_decoder_model();
        bpp_reg        = BPP_RESET;
        width_reg      = WIDTH_RESET;
        height_reg     = HEIGHT_RESET;
        want_header    = 1'b1;
        in_run         = 1'b0;
        left_in_packet = '0;
        byte_idx       = 0;
        pix_acc        = '0;
        image_pixels   = '0;
    endfunction

    // A pixel size of zero behaves as one byte, and anything above the maximum as the maximum.
    function automatic int unsigned active_bpp();
        if (bpp_reg == 0)
            return 1;
        if (bpp_reg > MAX_BPP)
            return MAX_BPP;
        return bpp_reg;
    endfunction

    // Advances the predicted decoder by one compressed byte and records any result it causes.
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [32:0]   total;
        logic [7:0]    len;
        pixel_result_t res;
        total = width_reg * height_reg;
        if (want_header) begin
            len = (b & HDR_COUNT_MASK) + 8'd1;
            if (image_pixels + len > total) begin
                // The packet would run past the end of the image: report it and start over.
                image_pixels   = '0;
                want_header    = 1'b1;
                in_run         = 1'b0;
                left_in_packet = '0;
                byte_idx       = 0;
                pix_acc        = '0;
                res.pixel      = '0;
                res.rep        = '0;
                res.done       = 1'b1;
                res.err        = 1'b1;
                pixels_due.push_back(res);
                return;
            end
            want_header    = 1'b0;
            in_run         = (b & HDR_RUN_FLAG) != 0;
            left_in_packet = len;
            byte_idx       = 0;
            pix_acc        = '0;
            return;
        end
        // Pixel bytes are packed with the first byte in the low bits.
        pix_acc  = pix_acc | (32'(b) << (8 * byte_idx));
        byte_idx = byte_idx + 1;
        if (byte_idx < active_bpp())
            return;
        res.pixel = pix_acc;
        pix_acc   = '0;
        byte_idx  = 0;
        if (in_run) begin
            res.rep        = left_in_packet;
            left_in_packet = '0;
        end else begin
            res.rep        = 8'd1;
            left_in_packet = left_in_packet - 8'd1;
        end
        image_pixels = image_pixels + res.rep;
        if (left_in_packet == 0)
            want_header = 1'b1;
        // The image ends only on an exact hit of the current pixel total.
        res.done = (image_pixels == total);
        res.err  = 1'b0;
        if (res.done) begin
            image_pixels   = '0;
            want_header    = 1'b1;
            left_in_packet = '0;
        end
        pixels_due.push_back(res);
    endfunction

    function automatic void apply_cfg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_BPP:    bpp_reg    = value[BPP_W-1:0];
            CFG_WIDTH:  width_reg  = value;
            CFG_HEIGHT: height_reg = value;
            default:    ;
        endcase
    endfunction

    function automatic void check_pixel(input pixel_result_t got);
        pixel_result_t want;
        if (pixels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected result: value %h repeat %0d done %b error %b",
                         got.pixel, got.rep, got.done, got.err);
            return;
        end
        want = pixels_due.pop_front();
        if (got.pixel !== want.pixel || got.rep !== want.rep ||
            got.done !== want.done || got.err !== want.err) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("result mismatch: expected value %h repeat %0d done %b error %b, got value %h repeat %0d done %b error %b",
                         want.pixel, want.rep, want.done, want.err,
                         got.pixel, got.rep, got.done, got.err);
        end
    endfunction

    // Driver. A configuration write is applied to the predictor at the edge where the
    // decoder takes it; an accepted byte transaction is predicted at the edge of the
    // handshake. The next byte is only offered once the current one has gone through,
    // and while idling is on, random gaps are placed between bytes.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left = 0;
            reset_decoder_model();
        end else begin
            if (cfg_we)
                apply_cfg_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata);
            if (s_axis_tvalid && !s_axis_tready) begin
                // The offered byte stays on the bus until the decoder takes it.
            end else if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (stream_bytes.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= stream_bytes.pop_front();
                if (idle_on && !calm && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 4);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor. Checks every result transaction and, while idling is on, applies random
    // back-pressure in bursts.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_pixel({m_axis_tdata[PIX_W-1:0], m_axis_tdata[PIX_W +: REP_W],
                             m_axis_tlast, m_axis_tuser});
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_on && !calm && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either side means the decoder hangs.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void queue_byte(input logic [BYTE_W-1:0] b);
        stream_bytes.push_back(b);
        items_queued++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Waits until every queued byte is taken and every predicted result has come back,
    // then waits DRAIN_CYCLES more falling edges. Ends on a falling edge, so the
    // predictor state can be read safely afterwards.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (stream_bytes.size() != 0 || s_axis_tvalid || pixels_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Feeds random bytes until the decoder is back in front of a packet header.
    task automatic finish_packet();
        int unsigned n;
        while (!want_header) begin
            n = (in_run ? 1 : left_in_packet) * active_bpp();
            n = (n > byte_idx) ? n - byte_idx : 1;
            repeat (n) queue_byte(8'($urandom_range(0, 255)));
            wait_drained();
        end
    endtask

    // Queues well-formed packets with random content, continuing the image that the
    // decoder is in and starting new ones as images fill up. Now and then a header that
    // overruns the rest of the image is put in instead. Raw packets are mostly short.
    task automatic queue_packets(input int unsigned n_packets);
        longint unsigned total;
        longint unsigned rem;
        int unsigned     bpp;
        int unsigned     cap;
        int unsigned     len;
        logic            is_run;
        total = width_reg * height_reg;
        bpp   = active_bpp();
        if (image_pixels >= total) begin
            // A smaller image was set mid-image, so the next header must overrun.
            queue_byte(8'($urandom_range(0, 255)));
            rem = total;
        end else begin
            rem = total - image_pixels;
        end
        for (int p = 0; p < n_packets; p++) begin
            if (rem == 0)
                rem = total;
            cap = (rem < 128) ? int'(rem) : 128;
            if (rem < 128 && $urandom_range(0, 11) == 0) begin
                queue_byte({1'($urandom_range(0, 1)), 7'(rem)});
                rem = total;
            end else begin
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, cap);
                else
                    len = $urandom_range(1, (cap < 6) ? cap : 6);
                is_run = 1'($urandom_range(0, 1));
                queue_byte({is_run, 7'(len - 1)});
                repeat ((is_run ? 1 : len) * bpp) queue_byte(8'($urandom_range(0, 255)));
                rem = rem - len;
            end
        end
    endtask

    // Stimulus sequencer.
    initial begin
        int unsigned        sel;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [CFG_DATA_W-1:0] bpp_val;
        longint unsigned    total;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening at the reset configuration: four-byte pixels, a 1 x 1 image.
        // A single raw pixel and a single run pixel each complete the image, and headers
        // asking for two and for 128 pixels overrun it.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(8'hA5);
        queue_byte(8'h5A);
        queue_byte(HDR_RUN_FLAG);
        queue_byte(8'h01);
        queue_byte(8'h02);
        queue_byte(8'h03);
        queue_byte(8'h04);
        queue_byte(8'h01);
        queue_byte(8'hFF);
        wait_drained();

        // The unimplemented index must change nothing. Then one-byte pixels on a 16 x 8
        // image: the longest run fills the whole image, followed by a short run and a
        // short raw packet.
        write_reg(CFG_SPARE, 16'hFFFF);
        write_reg(CFG_BPP, 16'd1);
        write_reg(CFG_WIDTH, 16'd16);
        write_reg(CFG_HEIGHT, 16'd8);
        wait_drained();
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(8'h81);
        queue_byte(8'h00);
        queue_byte(8'h01);
        queue_byte(8'h12);
        queue_byte(8'h34);
        wait_drained();

        // Random phases. Each phase waits for the decoder to drain before the registers
        // change, which also gives a pause with nothing in flight between phases.
        while (items_queued < ITEM_GOAL) begin
            if (items_queued > CALM_AFTER)
                calm = 1'b1;
            idle_on = !calm && $urandom_range(0, 3) != 0;

            sel = $urandom_range(0, 11);
            if ($urandom_range(0, 4) == 0)
                bpp_val = 16'($urandom);
            else
                bpp_val = 16'($urandom_range(0, 7));
            case (sel)
                7: begin
                    w = 16'hFFFF;
                    h = 16'hFFFF;
                end
                8: begin
                    w = 16'($urandom_range(1, 65535));
                    h = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom_range(1, 65535));
                end
                9: begin
                    // An empty image: every header overruns.
                    if ($urandom_range(0, 1) == 0) begin
                        w = '0;
                        h = 16'($urandom_range(0, 65535));
                    end else begin
                        w = 16'($urandom_range(1, 65535));
                        h = '0;
                    end
                end
                10: begin
                    w = 16'd1;
                    h = 16'd1;
                end
                default: begin
                    w = 16'($urandom_range(1, 12));
                    h = 16'($urandom_range(1, 12));
                end
            endcase

            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_SPARE, 16'($urandom));
            write_reg(CFG_BPP, bpp_val);
            // Selection 11 changes only the pixel size, in the middle of an image.
            if (sel != 11) begin
                write_reg(CFG_WIDTH, w);
                write_reg(CFG_HEIGHT, h);
            end
            wait_drained();
            finish_packet();

            total = width_reg * height_reg;
            if (total == 0) begin
                repeat ($urandom_range(2, 6)) queue_byte(8'($urandom_range(0, 255)));
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(4, 16)) queue_byte(8'($urandom_range(0, 255)));
            end else begin
                queue_packets($urandom_range(2, 20));
            end
            wait_drained();
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pixels_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
